@@ hdl/assert_macros.svh @@
// assertion macros used by the sample alignment search rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SAS_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SAS_ASSERT(lbl, clk, rst_n, prop, msg)

`define SAS_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hdl/sas_pkg.sv @@
// types and constants of the sample alignment search
`timescale 1ns / 1ps

package sas_pkg;

  localparam int SAMPLE_W = 8;
  localparam int ERROR_W  = 16;
  localparam int SHIFT_W  = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [ERROR_W-1:0] ERROR_NONE = 16'hFFFF;
  localparam logic [SHIFT_W-1:0] SHIFT_NONE = 9'h1FF;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_RUN,
    ST_DRAIN,
    ST_MUL,
    ST_CMP,
    ST_PREP,
    ST_DIV,
    ST_HOLD
  } sas_state_t;

endpackage

@@ hdl/sas_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sample_alignment_search.sv @@
// sample alignment search: 1-d offset search by least mean absolute difference
// load: one word taken per cycle while in the load state; after the last word the search
// scores each shift with nonempty overlap, passes over each empty shift, then divides the
// best sum by its overlap (quotient setup, 16 divider steps, output load); throughput set by the
// one read port of each sample ram, one pair compared per cycle
// reset: rst_n synchronous active low clears count, sequencer, margin and output valid
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sample_alignment_search
  import sas_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int MAX_MARGIN = 255
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,   // search_margin
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // sample_a [7:0], sample_b [15:8]
  input  logic                   in_tlast,      // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // best_error [15:0], best_shift [24:16], zeros
  output logic                   out_tuser      // no_match
);

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int SUM_W  = CNT_W + SAMPLE_W;
  localparam int PROD_W = SUM_W + CNT_W;
  localparam int MAG_W  = $clog2(MAX_MARGIN + 1);
  localparam int MW     = (MAG_W > 8) ? MAG_W : 8;
  localparam int XW     = (MAG_W > CNT_W) ? MAG_W : CNT_W;
  localparam int SW     = (MAG_W > SHIFT_W) ? MAG_W : SHIFT_W;

  sas_state_t state_r, state_nxt;

  logic [7:0]          cfg_margin_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                neg_r, neg_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic                rd_vld_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PROD_W-1:0]   prod_new_r, prod_best_r;
  logic                found_r, found_nxt;
  logic [SUM_W-1:0]    best_sum_r, best_sum_nxt;
  logic [CNT_W-1:0]    best_n_r, best_n_nxt;
  logic [MAG_W-1:0]    best_mag_r, best_mag_nxt;
  logic                best_neg_r, best_neg_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [ERROR_W-1:0]  dq_r, dq_nxt;
  logic [3:0]          div_cnt_r, div_cnt_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [ERROR_W-1:0]  out_error_r;
  logic [SHIFT_W-1:0]  out_shift_r;
  logic                out_nomatch_r;

  logic [MW-1:0]       margin_cap;
  logic [MAG_W-1:0]    margin_m;
  logic                in_acc, store_we, start;
  logic                skip, last_shift, upd;
  logic                nx_neg;
  logic [MAG_W-1:0]    nx_mag;
  logic [CNT_W-1:0]    addr_off;
  logic [ADDR_W-1:0]   raddr_a, raddr_b;
  logic [SAMPLE_W-1:0] rdata_a, rdata_b, absd;
  logic [CNT_W:0]      div_t;
  logic                div_ge;
  logic [SW-1:0]       mag_w, shift_w;
  logic                rd_en, out_load;

  // memories
  sas_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_first_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  sas_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_second_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // shared decode
  always_comb begin
    margin_cap = (MW'(cfg_margin_r) > MW'(MAX_MARGIN)) ? MW'(MAX_MARGIN) : MW'(cfg_margin_r);
    margin_m   = MAG_W'(margin_cap);
    in_acc     = in_tvalid && in_tready;
    store_we   = in_acc && (count_r < CNT_W'(MAX_LEN));
    start      = in_acc && in_tlast;
    skip       = XW'(mag_r) >= XW'(count_r);
    last_shift = !neg_r && (mag_r == margin_m);
    upd        = !found_r || (prod_new_r < prod_best_r);
    if (neg_r) begin
      nx_neg = (mag_r != MAG_W'(1));
      nx_mag = (mag_r == MAG_W'(1)) ? '0 : mag_r - MAG_W'(1);
    end else begin
      nx_neg = 1'b0;
      nx_mag = mag_r + MAG_W'(1);
    end
    addr_off = j_r + CNT_W'(mag_r);
    raddr_a  = neg_r ? j_r[ADDR_W-1:0] : addr_off[ADDR_W-1:0];
    raddr_b  = neg_r ? addr_off[ADDR_W-1:0] : j_r[ADDR_W-1:0];
    absd     = (rdata_a > rdata_b) ? rdata_a - rdata_b : rdata_b - rdata_a;
    div_t    = {rem_r, dq_r[ERROR_W-1]};
    div_ge   = div_t >= {1'b0, best_n_r};
    mag_w    = SW'(best_mag_r);
    shift_w  = best_neg_r ? (~mag_w + SW'(1)) : mag_w;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!skip) begin
          state_nxt = ST_RUN;
        end else if (last_shift) begin
          state_nxt = found_r ? ST_PREP : ST_HOLD;
        end
      end
      ST_RUN: begin
        if (j_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CMP;
      ST_CMP: begin
        state_nxt = last_shift ? ST_PREP : ST_SHIFT;
      end
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == 4'd15) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_LOAD);
    rd_en     = (state_r == ST_RUN);
    out_load  = (state_r == ST_HOLD) && (!out_tvalid_r || out_tready);
  end

  // datapath next values
  always_comb begin
    count_nxt      = count_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    n_nxt          = n_r;
    j_nxt          = j_r;
    sum_nxt        = sum_r;
    found_nxt      = found_r;
    best_sum_nxt   = best_sum_r;
    best_n_nxt     = best_n_r;
    best_mag_nxt   = best_mag_r;
    best_neg_nxt   = best_neg_r;
    rem_nxt        = rem_r;
    dq_nxt         = dq_r;
    div_cnt_nxt    = div_cnt_r;
    out_tvalid_nxt = out_tvalid_r;

    if (store_we) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (start) begin
      neg_nxt   = (margin_m != '0);
      mag_nxt   = margin_m;
      found_nxt = 1'b0;
    end
    if (state_r == ST_SHIFT) begin
      n_nxt   = count_r - CNT_W'(mag_r);
      j_nxt   = '0;
      sum_nxt = '0;
      if (skip) begin
        neg_nxt = nx_neg;
        mag_nxt = nx_mag;
      end
    end
    if (rd_en) begin
      j_nxt = j_r + CNT_W'(1);
    end
    if (rd_vld_r) begin
      sum_nxt = sum_r + SUM_W'(absd);
    end
    if (state_r == ST_CMP) begin
      neg_nxt = nx_neg;
      mag_nxt = nx_mag;
      if (upd) begin
        found_nxt    = 1'b1;
        best_sum_nxt = sum_r;
        best_n_nxt   = n_r;
        best_mag_nxt = mag_r;
        best_neg_nxt = neg_r;
      end
    end
    if (state_r == ST_PREP) begin
      rem_nxt     = best_sum_r[SUM_W-1:SAMPLE_W];
      dq_nxt      = {best_sum_r[SAMPLE_W-1:0], 8'h00};
      div_cnt_nxt = '0;
    end
    if (state_r == ST_DIV) begin
      rem_nxt     = div_ge ? CNT_W'(div_t - {1'b0, best_n_r}) : div_t[CNT_W-1:0];
      dq_nxt      = {dq_r[ERROR_W-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + 4'd1;
    end
    if (out_load) begin
      count_nxt      = '0;
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      cfg_margin_r <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_vld_r     <= rd_en;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        cfg_margin_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    sum_r       <= sum_nxt;
    best_sum_r  <= best_sum_nxt;
    best_n_r    <= best_n_nxt;
    best_mag_r  <= best_mag_nxt;
    best_neg_r  <= best_neg_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    div_cnt_r   <= div_cnt_nxt;
    prod_new_r  <= PROD_W'(sum_r) * PROD_W'(best_n_r);
    prod_best_r <= PROD_W'(best_sum_r) * PROD_W'(n_r);
    if (out_load) begin
      out_error_r   <= found_r ? dq_r : ERROR_NONE;
      out_shift_r   <= found_r ? shift_w[SHIFT_W-1:0] : SHIFT_NONE;
      out_nomatch_r <= !found_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ERROR_W - SHIFT_W){1'b0}}, out_shift_r, out_error_r};
  assign out_tuser  = out_nomatch_r;

  `SAS_NEVER(a_count_bound, clk, rst_n, count_r > CNT_W'(MAX_LEN), "load count above store depth")
  `SAS_ASSERT(a_acc_in_scan, clk, rst_n, rd_vld_r |-> (state_r == ST_RUN || state_r == ST_DRAIN), "accumulate outside scan")
  `SAS_ASSERT(a_index_bound, clk, rst_n, (state_r == ST_RUN) |-> (j_r < n_r), "scan index beyond overlap")
  `SAS_ASSERT(a_start, clk, rst_n, (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_SHIFT), "last word did not start search")
  `SAS_ASSERT(a_nomatch, clk, rst_n, (out_tvalid && out_tuser) |-> (out_shift_r == SHIFT_NONE && out_error_r == ERROR_NONE), "no match word with wrong fields")

endmodule
